>>> hw/rtl/rwl_pkg.sv
// Shared types and codes for the recursive reader-writer lock.
package rwl_pkg;

  localparam int unsigned CountBitsDefault = 16;
  localparam int unsigned IdBitsDefault    = 8;

  // Operation codes.
  localparam logic [2:0] OpReqRead    = 3'd0;
  localparam logic [2:0] OpRelRead    = 3'd1;
  localparam logic [2:0] OpReqWrite   = 3'd2;
  localparam logic [2:0] OpRelWrite   = 3'd3;
  localparam logic [2:0] OpRetryWrite = 3'd4;
  localparam logic [2:0] OpAbandon    = 3'd5;

  // Status codes.
  localparam logic [2:0] StGranted    = 3'd0;
  localparam logic [2:0] StWait       = 3'd1;
  localparam logic [2:0] StBusy       = 3'd2;
  localparam logic [2:0] StNotOwner   = 3'd3;
  localparam logic [2:0] StWrongOrder = 3'd4;
  localparam logic [2:0] StOverflow   = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] requester_id;
    logic       may_wait;
  } rwl_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        wake_writer;
    logic        read_gate_open;
    logic [15:0] read_count;
    logic [15:0] write_depth;
    logic [15:0] writer_read_depth;
    logic [15:0] writers_waiting;
    logic        is_write_owner;
  } rwl_out_t;

endpackage

>>> hw/rtl/rwl_core.sv
// Lock state registers and the per-operation update logic.
module rwl_core #(
  parameter int unsigned COUNT_BITS = rwl_pkg::CountBitsDefault,
  parameter int unsigned ID_BITS    = rwl_pkg::IdBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  rwl_pkg::rwl_in_t word_i,
  output rwl_pkg::rwl_out_t result_o
);

  localparam int unsigned CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int unsigned IW = (ID_BITS > 8) ? ID_BITS : 8;

  logic [COUNT_BITS-1:0] rc_q, rc_d, wd_q, wd_d, wnr_q, wnr_d, ww_q, ww_d;
  logic [ID_BITS-1:0]    own_id_q, own_id_d;
  logic                  own_v_q, own_v_d;
  logic                  gate_q, gate_d;
  logic                  gnc_q, gnc_d;

  logic [IW-1:0]         id_ext;
  logic [ID_BITS-1:0]    id;
  logic                  is_own;
  logic [2:0]            status;
  logic                  wake;
  logic [CW-1:0]         rc_ext, wd_ext, wnr_ext, ww_ext;

  assign id_ext = IW'(word_i.requester_id);
  assign id     = id_ext[ID_BITS-1:0];
  assign is_own = own_v_q && (own_id_q == id);

  always_comb begin
    rc_d     = rc_q;
    wd_d     = wd_q;
    wnr_d    = wnr_q;
    ww_d     = ww_q;
    own_id_d = own_id_q;
    own_v_d  = own_v_q;
    gate_d   = gate_q;
    gnc_d    = gnc_q;
    status   = rwl_pkg::StBusy;
    wake     = 1'b0;
    unique case (word_i.op)
      rwl_pkg::OpReqRead: begin
        if (!own_v_q) begin
          if (&rc_q) begin
            status = rwl_pkg::StOverflow;
          end else begin
            rc_d   = rc_q + 1'b1;
            status = rwl_pkg::StGranted;
          end
        end else if (own_id_q == id) begin
          if (&wnr_q) begin
            status = rwl_pkg::StOverflow;
          end else begin
            wnr_d  = wnr_q + 1'b1;
            status = rwl_pkg::StGranted;
          end
        end else begin
          status = word_i.may_wait ? rwl_pkg::StWait : rwl_pkg::StBusy;
        end
      end
      rwl_pkg::OpRelRead: begin
        if (!own_v_q) begin
          if (rc_q != '0) begin
            rc_d = rc_q - 1'b1;
            // The last shared hold going away wakes a waiting writer.
            wake   = (ww_q != '0) && (rc_d == '0);
            status = rwl_pkg::StGranted;
          end else begin
            status = rwl_pkg::StNotOwner;
          end
        end else if ((own_id_q == id) && (wnr_q != '0)) begin
          wnr_d  = wnr_q - 1'b1;
          status = rwl_pkg::StGranted;
        end else begin
          status = rwl_pkg::StNotOwner;
        end
      end
      rwl_pkg::OpReqWrite: begin
        if ((rc_q == '0) &&
            (((wd_q == '0) && ((ww_q == '0) || !word_i.may_wait)) || is_own)) begin
          if (&wd_q) begin
            status = rwl_pkg::StOverflow;
          end else begin
            if (gnc_q) begin
              gnc_d  = 1'b0;
              gate_d = 1'b0;
            end
            wd_d     = wd_q + 1'b1;
            own_id_d = id;
            own_v_d  = 1'b1;
            status   = rwl_pkg::StGranted;
          end
        end else if (word_i.may_wait) begin
          if (&ww_q) begin
            status = rwl_pkg::StOverflow;
          end else begin
            ww_d   = ww_q + 1'b1;
            status = rwl_pkg::StWait;
          end
        end else begin
          status = rwl_pkg::StBusy;
        end
      end
      rwl_pkg::OpRelWrite: begin
        if (!is_own) begin
          status = rwl_pkg::StNotOwner;
        end else if ((wd_q <= COUNT_BITS'(1)) && (wnr_q != '0)) begin
          status = rwl_pkg::StWrongOrder;
        end else begin
          if (wd_q != '0) begin
            wd_d = wd_q - 1'b1;
          end
          if (wd_q <= COUNT_BITS'(1)) begin
            own_v_d  = 1'b0;
            own_id_d = '0;
          end
          if (ww_q == '0) begin
            gate_d = 1'b1;
            gnc_d  = 1'b1;
          end else begin
            wake = 1'b1;
          end
          status = rwl_pkg::StGranted;
        end
      end
      rwl_pkg::OpRetryWrite: begin
        if (ww_q == '0) begin
          status = rwl_pkg::StNotOwner;
        end else if ((rc_q == '0) && ((wd_q == '0) || is_own)) begin
          if (&wd_q) begin
            status = rwl_pkg::StOverflow;
          end else begin
            if (gnc_q) begin
              gnc_d  = 1'b0;
              gate_d = 1'b0;
            end
            wd_d     = wd_q + 1'b1;
            own_id_d = id;
            own_v_d  = 1'b1;
            ww_d     = ww_q - 1'b1;
            status   = rwl_pkg::StGranted;
          end
        end else begin
          status = rwl_pkg::StWait;
        end
      end
      rwl_pkg::OpAbandon: begin
        if (ww_q != '0) begin
          ww_d   = ww_q - 1'b1;
          status = rwl_pkg::StGranted;
        end else begin
          status = rwl_pkg::StNotOwner;
        end
      end
      default: begin
        status = rwl_pkg::StBusy;
      end
    endcase
  end

  assign rc_ext  = CW'(rc_d);
  assign wd_ext  = CW'(wd_d);
  assign wnr_ext = CW'(wnr_d);
  assign ww_ext  = CW'(ww_d);

  always_comb begin
    result_o                   = '0;
    result_o.status            = status;
    result_o.wake_writer       = wake;
    result_o.read_gate_open    = gate_d;
    result_o.read_count        = rc_ext[15:0];
    result_o.write_depth       = wd_ext[15:0];
    result_o.writer_read_depth = wnr_ext[15:0];
    result_o.writers_waiting   = ww_ext[15:0];
    result_o.is_write_owner    = own_v_d && (own_id_d == id);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q     <= '0;
      wd_q     <= '0;
      wnr_q    <= '0;
      ww_q     <= '0;
      own_id_q <= '0;
      own_v_q  <= 1'b0;
      gate_q   <= 1'b1;
      gnc_q    <= 1'b1;
    end else if (fire_i) begin
      rc_q     <= rc_d;
      wd_q     <= wd_d;
      wnr_q    <= wnr_d;
      ww_q     <= ww_d;
      own_id_q <= own_id_d;
      own_v_q  <= own_v_d;
      gate_q   <= gate_d;
      gnc_q    <= gnc_d;
    end
  end

endmodule

>>> hw/rtl/recursive_reader_writer_lock.sv
// Top level of the recursive reader-writer lock: input register, core and result register.
//
// Each accepted word is one lock operation and yields exactly one result word, in order.
// A word is held in the input register, where the lock state is read and updated
// by the core, and then waits in the result register until taken; the core logic between
// input register and result register is combinational, so one operation per cycle is
// sustained while the result register is not stalled. The input side stalls
// only while the input register holds a word and the result register is full and stalled.
module recursive_reader_writer_lock #(
  parameter int unsigned COUNT_BITS = rwl_pkg::CountBitsDefault,
  parameter int unsigned ID_BITS    = rwl_pkg::IdBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rwl_pkg::rwl_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rwl_pkg::rwl_out_t out_word_o
);

  logic              in_valid_q;
  rwl_pkg::rwl_in_t  in_word_q;
  logic              out_valid_q;
  rwl_pkg::rwl_out_t out_word_q;
  rwl_pkg::rwl_out_t result;
  logic              advance;
  logic              accept;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  rwl_core #(
    .COUNT_BITS(COUNT_BITS),
    .ID_BITS   (ID_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .word_i  (in_word_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_word_q <= in_word_i;
    end
    if (advance) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
